// ===== sv/dqs_pkg.sv =====
// Package for the bounded deque with search: field widths, codes and payload types.
package dqs_pkg;

  // Fixed field widths of the command and result payloads.
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Command opcodes.
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd3;

  // What a storage cell does in one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_LOAD
  } cell_op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  // Command payload.
  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // Result payload.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

// ===== sv/bounded_deque_with_search.sv =====
// Top level of the bounded deque with search: a ring of cells and its controller.
//
// Usage: commands arrive on cmd (opcode and value) with cmd_valid/cmd_ready, and
// each command gives exactly one result on res (status, position, count) with
// res_valid/res_ready. Entries sit in a row of DEPTH cells with the front in
// cell 0. Push front shifts the row toward the back, push back loads the cell
// at the tail, pop front rotates the row by one, pop back only drops the count.
// Pushes, pops, unknown opcodes and searches of an empty list finish in the
// transfer cycle; their result is in the output register in the next cycle.
// A search rotates the whole ring through cell 0 once, comparing one entry a
// cycle, and no new command is taken until its result has been loaded into
// the output register.
// One command is in work at a time; cmd_ready is high only while the
// controller is idle and the output register is free or being emptied.
// When the receiver stalls, the result holds in the output register and the
// next command waits. Reset clears the count, the controller state and the
// output valid; the cells keep their contents and are read only once written.
module bounded_deque_with_search #(
  parameter int DEPTH      = dqs_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  dqs_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output dqs_pkg::res_t res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_STEP  = IW'(DEPTH - 1);

  // Registers.
  dqs_pkg::state_t       state;
  dqs_pkg::state_t       state_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [IW-1:0]         step;
  logic [IW-1:0]         pos;
  logic                  found;
  logic [DATA_WIDTH-1:0] key;

  // Controller outputs.
  dqs_pkg::cell_op_t     mode;
  logic                  res_load;
  dqs_pkg::res_t         res_next;
  logic                  search_start;

  logic                  accept;
  logic                  out_free;
  logic                  is_full;
  logic                  is_empty;
  logic                  hit;
  logic [DATA_WIDTH-1:0] word_in;
  logic [DATA_WIDTH-1:0] words [DEPTH];
  dqs_pkg::cell_op_t     cell_op [DEPTH];

  assign accept   = cmd_valid && cmd_ready;
  assign out_free = !res_valid || res_ready;
  assign is_full  = (count == FULL_COUNT);
  assign is_empty = (count == '0);

  // Fit the command value to the stored word width.
  generate
    if (DATA_WIDTH <= dqs_pkg::VALUE_W) begin : g_trunc
      assign word_in = cmd.value[DATA_WIDTH-1:0];
    end else begin : g_sext
      assign word_in = {{(DATA_WIDTH - dqs_pkg::VALUE_W){cmd.value[dqs_pkg::VALUE_W-1]}},
                        cmd.value};
    end
  endgenerate

  // The row of cells; the last cell wraps to cell 0 so the row can rotate.
  generate
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_w;
      logic [DATA_WIDTH-1:0] next_w;

      if (k == 0) begin : g_first
        assign prev_w = word_in;
      end else begin : g_mid_prev
        assign prev_w = words[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
        assign next_w = words[0];
      end else begin : g_mid_next
        assign next_w = words[k+1];
      end

      // A load goes only to the cell at the tail.
      always_comb begin
        if (mode == dqs_pkg::CELL_LOAD) begin
          cell_op[k] = (count == CW'(k)) ? dqs_pkg::CELL_LOAD : dqs_pkg::CELL_HOLD;
        end else begin
          cell_op[k] = mode;
        end
      end

      dqs_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk       (clk),
        .op        (cell_op[k]),
        .prev_word (prev_w),
        .next_word (next_w),
        .load_word (word_in),
        .word      (words[k])
      );
    end
  endgenerate

  // The entry now in cell 0 is a first match if it is occupied and equals the key.
  assign hit = !found && (CW'(step) < count) && (words[0] == key);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dqs_pkg::ST_IDLE: begin
        if (accept && cmd.opcode == dqs_pkg::OP_SEARCH && !is_empty) begin
          state_next = dqs_pkg::ST_SEARCH;
        end
      end
      dqs_pkg::ST_SEARCH: begin
        if (step == LAST_STEP) begin
          state_next = dqs_pkg::ST_RESULT;
        end
      end
      dqs_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = dqs_pkg::ST_IDLE;
        end
      end
      default: state_next = dqs_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs: cell mode, count update and result.
  always_comb begin
    cmd_ready         = (state == dqs_pkg::ST_IDLE) && out_free;
    mode              = dqs_pkg::CELL_HOLD;
    count_next        = count;
    res_load          = 1'b0;
    search_start      = 1'b0;
    res_next.status   = dqs_pkg::STAT_DONE;
    res_next.position = '0;
    case (state)
      dqs_pkg::ST_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (cmd.opcode)
            dqs_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                res_next.status = dqs_pkg::STAT_FULL;
              end else begin
                mode       = dqs_pkg::CELL_FROM_PREV;
                count_next = count + CW'(1);
              end
            end
            dqs_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                res_next.status = dqs_pkg::STAT_FULL;
              end else begin
                mode       = dqs_pkg::CELL_LOAD;
                count_next = count + CW'(1);
              end
            end
            dqs_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                res_next.status = dqs_pkg::STAT_EMPTY;
              end else begin
                mode       = dqs_pkg::CELL_FROM_NEXT;
                count_next = count - CW'(1);
              end
            end
            dqs_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                res_next.status = dqs_pkg::STAT_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            dqs_pkg::OP_SEARCH: begin
              if (is_empty) begin
                res_next.status = dqs_pkg::STAT_EMPTY;
              end else begin
                res_load     = 1'b0;
                search_start = 1'b1;
              end
            end
            default: begin
              res_next.status = dqs_pkg::STAT_DONE;
            end
          endcase
        end
      end
      dqs_pkg::ST_SEARCH: begin
        mode = dqs_pkg::CELL_FROM_NEXT;
      end
      dqs_pkg::ST_RESULT: begin
        if (out_free) begin
          res_load = 1'b1;
          if (found) begin
            res_next.status   = dqs_pkg::STAT_DONE;
            res_next.position = dqs_pkg::POS_W'(pos);
          end else begin
            res_next.status = dqs_pkg::STAT_MISS;
          end
        end
      end
      default: begin
        mode = dqs_pkg::CELL_HOLD;
      end
    endcase
    res_next.count = dqs_pkg::COUNT_W'(count_next);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dqs_pkg::ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Search walk: step counter, key and first-match capture.
  always_ff @(posedge clk) begin
    if (search_start) begin
      key   <= word_in;
      step  <= '0;
      found <= 1'b0;
      pos   <= '0;
    end else if (state == dqs_pkg::ST_SEARCH) begin
      step <= step + IW'(1);
      if (hit) begin
        found <= 1'b1;
        pos   <= step;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  // The count never goes past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count exceeds depth");

  // Commands are taken only while the controller is idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> state == dqs_pkg::ST_IDLE)
    else $error("command ready outside idle");

  // A search walk advances one step a cycle until the ring has turned once.
  a_step_walk: assert property (@(posedge clk) disable iff (rst)
    (state == dqs_pkg::ST_SEARCH && step != LAST_STEP)
      |=> (state == dqs_pkg::ST_SEARCH && step == IW'($past(step) + IW'(1))))
    else $error("search walk skipped a step");

  // The count holds steady while the ring rotates.
  a_count_search: assert property (@(posedge clk) disable iff (rst)
    state == dqs_pkg::ST_SEARCH |=> $stable(count))
    else $error("count changed during search");

  // A match always lies inside the occupied entries.
  a_match_inside: assert property (@(posedge clk) disable iff (rst)
    (state == dqs_pkg::ST_RESULT && found) |-> CW'(pos) < count)
    else $error("match position beyond the entry count");

endmodule

// ===== sv/dqs_cell.sv =====
// One storage cell of the deque chain: holds a word, shifts from a neighbor or loads.
module dqs_cell #(
  parameter int DATA_WIDTH = dqs_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  dqs_pkg::cell_op_t      op,
  input  logic [DATA_WIDTH-1:0]  prev_word,
  input  logic [DATA_WIDTH-1:0]  next_word,
  input  logic [DATA_WIDTH-1:0]  load_word,
  output logic [DATA_WIDTH-1:0]  word
);

  // The stored word takes one of its neighbors, the new word, or holds.
  always_ff @(posedge clk) begin
    case (op)
      dqs_pkg::CELL_FROM_PREV: word <= prev_word;
      dqs_pkg::CELL_FROM_NEXT: word <= next_word;
      dqs_pkg::CELL_LOAD:      word <= load_word;
      default:                 word <= word;
    endcase
  end

endmodule
